// File: rtl/edge_histogram_extractor_core_macros.svh
// Assertion macros shared by the edge histogram extractor RTL.
`ifndef EDGE_HISTOGRAM_EXTRACTOR_CORE_MACROS_SVH
`define EDGE_HISTOGRAM_EXTRACTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define EHE_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("edge histogram assertion failed");
`define EHE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("edge histogram assertion failed");
`else
`define EHE_ASSERT(label, ante, cons)
`define EHE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/ehe_pkg.sv
// Package with the types, constants and helpers of the edge histogram extractor.
`default_nettype none

package ehe_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_BLOCK    = 256;
  localparam int COUNT_BITS   = 16;
  localparam int HEIGHT_LIMIT = 4096;

  localparam int QCOLS  = MAX_WIDTH / 2;
  localparam int QA_W   = $clog2(QCOLS);
  localparam int SUM_W  = 22;
  localparam int POS_W  = $clog2(MAX_WIDTH);
  localparam int OFS_W  = $clog2(MAX_BLOCK);
  localparam int CFG_W  = 13;
  localparam int BS_W   = 9;
  localparam int THR_W  = 22;
  localparam int STR_W  = 41;
  localparam int DIF_W  = SUM_W + 3;
  localparam int ABS_W  = SUM_W + 2;

  localparam logic [16:0] SQRT2_Q16 = 17'd92682;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_BLOCK_SIZE     = 2'd2;
  localparam logic [1:0] REG_EDGE_THRESHOLD = 2'd3;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [3:0]            region_index;
    logic [COUNT_BITS-1:0] vertical_count;
    logic [COUNT_BITS-1:0] horizontal_count;
    logic [COUNT_BITS-1:0] diag45_count;
    logic [COUNT_BITS-1:0] diag135_count;
    logic [COUNT_BITS-1:0] nondir_count;
    logic [COUNT_BITS-1:0] block_count;
    logic                  last_region;
  } result_t;

  typedef enum logic [2:0] {
    CLS_VERT, CLS_HORIZ, CLS_D45, CLS_D135, CLS_NONDIR, CLS_NONE
  } class_t;

  typedef enum logic [1:0] {
    ST_CLEAR, ST_RUN, ST_DRAIN, ST_EMIT
  } state_t;

  typedef logic [3:0][SUM_W-1:0] quad_t;

  typedef struct packed {
    logic [4:0][COUNT_BITS-1:0] edges;
    logic [COUNT_BITS-1:0]      blocks;
  } counts_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] region;
    quad_t      sums;
  } cls_req_t;

  typedef struct packed {
    logic       busy;
    logic       valid;
    logic [3:0] region;
    class_t     cls;
  } cls_rsp_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  // Division by three of a channel sum below 1024 by multiplying with 683/2048.
  function automatic logic [7:0] gray_of(input logic [9:0] s);
    logic [19:0] p;
    p = s * 10'd683;
    return p[18:11];
  endfunction

endpackage

`default_nettype wire

// File: rtl/ehe_classify.sv
// Pipelined edge classifier: quadrant sums in, edge class of the block out.
`default_nettype none

module ehe_classify (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [ehe_pkg::THR_W-1:0] thr,
  input  ehe_pkg::cls_req_t       cls_in,
  output ehe_pkg::cls_rsp_t       cls_out
);
  import ehe_pkg::*;

  function automatic logic [ABS_W-1:0] absd(input logic signed [DIF_W-1:0] d);
    logic signed [DIF_W-1:0] n;
    n = d[DIF_W-1] ? -d : d;
    return n[ABS_W-1:0];
  endfunction

  logic       a_v_r, b_v_r, c_v_r, o_v_r;
  logic [3:0] a_reg_r, b_reg_r, c_reg_r, o_reg_r;
  quad_t      a_s_r;
  class_t     o_cls_r;

  logic [4:0][STR_W-1:0] b_str_r, b_str_nxt;
  logic [STR_W-1:0]      c_b01_r, c_b23_r, c_nd_r;
  class_t                c_i01_r, c_i23_r;
  class_t                d_cls;

  logic signed [DIF_W-1:0] s1, s2, s3, s4;
  logic signed [DIF_W-1:0] dv, dh, d45, d135, dn;
  logic [STR_W-1:0]        best, thr_s;
  class_t                  best_i;

  always_comb begin
    s1 = $signed({3'b000, a_s_r[0]});
    s2 = $signed({3'b000, a_s_r[1]});
    s3 = $signed({3'b000, a_s_r[2]});
    s4 = $signed({3'b000, a_s_r[3]});
    dv   = s1 + s3 - s2 - s4;
    dh   = s1 + s2 - s3 - s4;
    d45  = s1 - s4;
    d135 = s2 - s3;
    dn   = s1 - s2 - s3 + s4;
    b_str_nxt[0] = {1'b0, absd(dv), 16'b0};
    b_str_nxt[1] = {1'b0, absd(dh), 16'b0};
    b_str_nxt[2] = STR_W'(absd(d45)) * STR_W'(SQRT2_Q16);
    b_str_nxt[3] = STR_W'(absd(d135)) * STR_W'(SQRT2_Q16);
    b_str_nxt[4] = {absd(dn), 17'b0};
  end

  // Ties go to the earlier class, so a later one wins only when strictly larger.
  always_comb begin
    thr_s  = STR_W'({thr, 16'b0});
    best   = c_b01_r;
    best_i = c_i01_r;
    if (c_b23_r > best) begin
      best   = c_b23_r;
      best_i = c_i23_r;
    end
    if (c_nd_r > best) begin
      best   = c_nd_r;
      best_i = CLS_NONDIR;
    end
    d_cls = (best < thr_s) ? CLS_NONE : best_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      a_v_r <= cls_in.valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      o_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    a_reg_r <= cls_in.region;
    a_s_r   <= cls_in.sums;
    b_reg_r <= a_reg_r;
    b_str_r <= b_str_nxt;
    c_reg_r <= b_reg_r;
    if (b_str_r[1] > b_str_r[0]) begin
      c_b01_r <= b_str_r[1];
      c_i01_r <= CLS_HORIZ;
    end else begin
      c_b01_r <= b_str_r[0];
      c_i01_r <= CLS_VERT;
    end
    if (b_str_r[3] > b_str_r[2]) begin
      c_b23_r <= b_str_r[3];
      c_i23_r <= CLS_D135;
    end else begin
      c_b23_r <= b_str_r[2];
      c_i23_r <= CLS_D45;
    end
    c_nd_r  <= b_str_r[4];
    o_reg_r <= c_reg_r;
    o_cls_r <= d_cls;
  end

  assign cls_out.busy   = a_v_r | b_v_r | c_v_r | o_v_r;
  assign cls_out.valid  = o_v_r;
  assign cls_out.region = o_reg_r;
  assign cls_out.cls    = o_cls_r;

endmodule

`default_nettype wire

// File: rtl/edge_histogram_extractor_core.sv
// Top level of the edge histogram extractor: pixel path, counts and result output.
`default_nettype none
`include "edge_histogram_extractor_core_macros.svh"

// RGB pixels enter in raster order on the in_ channel, one per cycle when the
// block is running. Each pixel goes to gray and is added into the quadrant sums
// of its block column, held in a 2048-word memory read and written once a cycle.
// A finished block passes a four-stage classifier and updates the counts of its
// region in the 4x4 grid. After the last pixel of the image, in_stall stays high
// while the last blocks finish and the sixteen region results leave on the
// out_ channel, one per cycle while out_stall is low; the counts clear as they
// are sent. The next image may start as soon as the sixteenth result sits in
// the output register.
// Throughput is one pixel per cycle within an image, set by the single
// read-modify-write port of the quadrant sum memory.
// After reset and after any register write the sum memory is cleared, one word
// a cycle, with in_stall high; registers may be written at any time the block
// is idle. A stalled result holds in the output register.
module edge_histogram_extractor_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ehe_pkg::pixel_t in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ehe_pkg::result_t out_data,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import ehe_pkg::*;

  // Configuration registers and derived values.
  logic [CFG_W-1:0] width_r, height_r;
  logic [BS_W-1:0]  bsize_r;
  logic [7:0]       thresh_r;
  logic             cfg_we;

  logic [CFG_W-1:0] w_r, h_r, w_c, h_c;
  logic [BS_W-1:0]  bs_r, bs_c, bs_even;
  logic [OFS_W-1:0] half_r;
  logic [14:0]      area_r;
  logic [THR_W-1:0] thr_r;
  logic [14:0]      w1_r, w2_r, w3_r, h1_r, h2_r, h3_r;

  state_t state_r, state_nxt;
  logic [QA_W-1:0] clr_addr_r;

  // Pixel position.
  logic [POS_W-1:0] col_r, row_r, x0_r, y0_r;
  logic [OFS_W-1:0] ox_r, oy_r;
  logic [QA_W-1:0]  bx_r;
  logic             in_fire, col_end, row_end, ox_end, oy_end, in_blk, last_px;
  logic [1:0]       rcol, rrow;
  logic [14:0]      x4, y4;

  // Sum pipeline.
  logic             p1_v_r, p1_blk_r, p1_end_r;
  logic [7:0]       p1_gray_r;
  logic [QA_W-1:0]  p1_addr_r;
  logic [1:0]       p1_lane_r;
  logic [3:0]       p1_reg_r;
  logic             p2_v_r, p2_blk_r, p2_end_r;
  logic [7:0]       p2_gray_r;
  logic [QA_W-1:0]  p2_addr_r;
  logic [1:0]       p2_lane_r;
  logic [3:0]       p2_reg_r;
  quad_t            qmem [QCOLS];
  quad_t            rd_r, fwd_word_r, p2_base, p2_sum, p2_wdata, mem_wd;
  logic             fwd_r, mem_we;
  logic [QA_W-1:0]  mem_wa;

  cls_req_t cls_in;
  cls_rsp_t cls_out;

  counts_t          cnt_r [16];
  counts_t          cnt_cur, cnt_upd;
  logic [3:0]       cnt_addr, emit_idx_r;
  logic             load;
  logic             out_valid_r;
  result_t          out_data_r;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(256);
      height_r <= CFG_W'(256);
      bsize_r  <= BS_W'(6);
      thresh_r <= 8'd11;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_IMAGE_WIDTH:    width_r  <= pwdata[CFG_W-1:0];
        REG_IMAGE_HEIGHT:   height_r <= pwdata[CFG_W-1:0];
        REG_BLOCK_SIZE:     bsize_r  <= pwdata[BS_W-1:0];
        REG_EDGE_THRESHOLD: thresh_r <= pwdata[7:0];
        default:            thresh_r <= thresh_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_IMAGE_WIDTH:    prdata = 32'(width_r);
      REG_IMAGE_HEIGHT:   prdata = 32'(height_r);
      REG_BLOCK_SIZE:     prdata = 32'(bsize_r);
      REG_EDGE_THRESHOLD: prdata = 32'(thresh_r);
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    w_c = (width_r < CFG_W'(2)) ? CFG_W'(2) :
          (width_r > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : width_r;
    h_c = (height_r < CFG_W'(2)) ? CFG_W'(2) :
          (height_r > CFG_W'(HEIGHT_LIMIT)) ? CFG_W'(HEIGHT_LIMIT) : height_r;
    bs_even = {bsize_r[BS_W-1:1], 1'b0};
    bs_c = (bs_even < BS_W'(2)) ? BS_W'(2) :
           (bs_even > BS_W'(MAX_BLOCK)) ? BS_W'(MAX_BLOCK) : bs_even;
  end

  // The derived values are registered in a chain (bs_r, half_r, area_r, thr_r) and settle well inside the clear pass.
  always_ff @(posedge clk) begin
    w_r    <= w_c;
    h_r    <= h_c;
    bs_r   <= bs_c;
    half_r <= bs_r[OFS_W:1];
    area_r <= 15'(half_r * half_r);
    thr_r  <= THR_W'(area_r * thresh_r);
    w1_r   <= 15'(w_r);
    w2_r   <= {1'b0, w_r, 1'b0};
    w3_r   <= 15'(w_r) + {1'b0, w_r, 1'b0};
    h1_r   <= 15'(h_r);
    h2_r   <= {1'b0, h_r, 1'b0};
    h3_r   <= 15'(h_r) + {1'b0, h_r, 1'b0};
  end

  // Control.
  assign in_stall = (state_r != ST_RUN);
  assign in_fire  = in_valid && !in_stall;
  assign load     = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_addr_r == QA_W'(QCOLS - 1)) state_nxt = ST_RUN;
      ST_RUN:   if (in_fire && last_px) state_nxt = ST_DRAIN;
      ST_DRAIN: if (!p1_v_r && !p2_v_r && !cls_out.busy) state_nxt = ST_EMIT;
      ST_EMIT:  if (load && emit_idx_r == 4'd15) state_nxt = ST_RUN;
      default:  state_nxt = ST_CLEAR;
    endcase
    if (cfg_we) state_nxt = ST_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we)          clr_addr_r <= '0;
    else if (state_r == ST_CLEAR)  clr_addr_r <= clr_addr_r + 1'b1;
  end

  // Position counters.
  always_comb begin
    col_end = ({1'b0, col_r} == w_r - 1'b1);
    row_end = ({1'b0, row_r} == h_r - 1'b1);
    ox_end  = ({1'b0, ox_r} == bs_r - 1'b1);
    oy_end  = ({1'b0, oy_r} == bs_r - 1'b1);
    last_px = col_end && row_end;
    in_blk  = (({1'b0, x0_r} + CFG_W'(bs_r)) <= w_r) &&
              (({1'b0, y0_r} + CFG_W'(bs_r)) <= h_r);
    x4   = {1'b0, x0_r, 2'b00};
    y4   = {1'b0, y0_r, 2'b00};
    rcol = 2'(x4 >= w1_r) + 2'(x4 >= w2_r) + 2'(x4 >= w3_r);
    rrow = 2'(y4 >= h1_r) + 2'(y4 >= h2_r) + 2'(y4 >= h3_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      col_r <= '0; row_r <= '0; x0_r <= '0; y0_r <= '0;
      ox_r  <= '0; oy_r  <= '0; bx_r <= '0;
    end else if (in_fire) begin
      if (col_end) begin
        col_r <= '0;
        x0_r  <= '0;
        ox_r  <= '0;
        bx_r  <= '0;
        if (row_end) begin
          row_r <= '0;
          y0_r  <= '0;
          oy_r  <= '0;
        end else begin
          row_r <= row_r + 1'b1;
          if (oy_end) begin
            oy_r <= '0;
            y0_r <= y0_r + POS_W'(bs_r);
          end else begin
            oy_r <= oy_r + 1'b1;
          end
        end
      end else begin
        col_r <= col_r + 1'b1;
        if (ox_end) begin
          ox_r <= '0;
          x0_r <= x0_r + POS_W'(bs_r);
          bx_r <= bx_r + 1'b1;
        end else begin
          ox_r <= ox_r + 1'b1;
        end
      end
    end
  end

  // Stage 1: gray value, memory address and block flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
    end else begin
      p1_v_r <= in_fire;
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_gray_r <= gray_of(10'(in_data.red) + 10'(in_data.green) + 10'(in_data.blue));
    p1_addr_r <= bx_r;
    p1_lane_r <= {oy_r >= half_r, ox_r >= half_r};
    p1_blk_r  <= in_blk;
    p1_end_r  <= in_blk && ox_end && oy_end;
    p1_reg_r  <= {rrow, rcol};
    p2_gray_r <= p1_gray_r;
    p2_addr_r <= p1_addr_r;
    p2_lane_r <= p1_lane_r;
    p2_blk_r  <= p1_blk_r;
    p2_end_r  <= p1_end_r;
    p2_reg_r  <= p1_reg_r;
    rd_r      <= qmem[p1_addr_r];
    // The word written this cycle is not yet in the memory read above.
    fwd_r      <= p2_v_r && p2_blk_r && (p2_addr_r == p1_addr_r);
    fwd_word_r <= p2_wdata;
  end

  // Stage 2: add the gray value into its quadrant, clear the word at block end.
  always_comb begin
    p2_base = fwd_r ? fwd_word_r : rd_r;
    p2_sum  = p2_base;
    p2_sum[p2_lane_r] = p2_base[p2_lane_r] + SUM_W'(p2_gray_r);
    p2_wdata = p2_end_r ? '0 : p2_sum;
    mem_we = (state_r == ST_CLEAR) || (p2_v_r && p2_blk_r);
    mem_wa = (state_r == ST_CLEAR) ? clr_addr_r : p2_addr_r;
    mem_wd = (state_r == ST_CLEAR) ? '0 : p2_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_we) qmem[mem_wa] <= mem_wd;
  end

  assign cls_in.valid  = p2_v_r && p2_end_r;
  assign cls_in.region = p2_reg_r;
  assign cls_in.sums   = p2_sum;

  ehe_classify u_classify (
    .clk     (clk),
    .rst_n   (rst_n),
    .thr     (thr_r),
    .cls_in  (cls_in),
    .cls_out (cls_out)
  );

  // Region counts, updated per finished block and drained at image end.
  always_comb begin
    cnt_addr = (state_r == ST_EMIT) ? emit_idx_r : cls_out.region;
    cnt_cur  = cnt_r[cnt_addr];
    cnt_upd  = cnt_cur;
    cnt_upd.blocks = sat_inc(cnt_cur.blocks);
    case (cls_out.cls)
      CLS_VERT:   cnt_upd.edges[0] = sat_inc(cnt_cur.edges[0]);
      CLS_HORIZ:  cnt_upd.edges[1] = sat_inc(cnt_cur.edges[1]);
      CLS_D45:    cnt_upd.edges[2] = sat_inc(cnt_cur.edges[2]);
      CLS_D135:   cnt_upd.edges[3] = sat_inc(cnt_cur.edges[3]);
      CLS_NONDIR: cnt_upd.edges[4] = sat_inc(cnt_cur.edges[4]);
      default:    cnt_upd.edges    = cnt_cur.edges;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      for (int i = 0; i < 16; i++) cnt_r[i] <= '0;
    end else if (load) begin
      cnt_r[cnt_addr] <= '0;
    end else if (cls_out.valid) begin
      cnt_r[cnt_addr] <= cnt_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) emit_idx_r <= '0;
    else if (load)        emit_idx_r <= emit_idx_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)          out_valid_r <= 1'b0;
    else if (load)       out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.region_index     <= emit_idx_r;
      out_data_r.vertical_count   <= cnt_cur.edges[0];
      out_data_r.horizontal_count <= cnt_cur.edges[1];
      out_data_r.diag45_count     <= cnt_cur.edges[2];
      out_data_r.diag135_count    <= cnt_cur.edges[3];
      out_data_r.nondir_count     <= cnt_cur.edges[4];
      out_data_r.block_count      <= cnt_cur.blocks;
      out_data_r.last_region      <= (emit_idx_r == 4'd15);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `EHE_ASSERT(a_emit_pipe_empty, state_r == ST_EMIT, !p1_v_r && !p2_v_r && !cls_out.busy)
  `EHE_ASSERT(a_clear_no_pixel, state_r == ST_CLEAR, !p2_v_r || !p2_blk_r || cfg_we)
  `EHE_ASSERT(a_last_is_region15, out_valid_r && out_data_r.last_region, &out_data_r.region_index)
  `EHE_ASSERT_NEXT(a_out_only_from_emit, !out_valid_r && state_r != ST_EMIT, !out_valid_r)

endmodule

`default_nettype wire
